@@ design/tlsr_pkg.sv @@
// Package for the time line sync receiver.
// Holds the request/result structs, parser phase codes, mode and register codes.
// No dependencies.
`timescale 1ns / 1ps

package tlsr_pkg;

  localparam int unsigned LineCapacity = 64;
  localparam int unsigned LineCntW     = $clog2(LineCapacity);

  localparam logic [15:0] RetryIntervalReset = 16'd5000;
  localparam logic [7:0]  MaxRequestsReset   = 8'd6;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChT     = 8'h54;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [6:0] MonthMax  = 7'd12;
  localparam logic [6:0] DayMax    = 7'd31;
  localparam logic [6:0] HourMax   = 7'd23;
  localparam logic [6:0] MinSecMax = 7'd59;

  typedef enum logic [1:0] {
    ModeByte  = 2'd0,
    ModeTick  = 2'd1,
    ModeStart = 2'd2,
    ModeNone  = 2'd3
  } mode_e;

  typedef enum logic {
    RegRetryInterval = 1'b0,
    RegMaxRequests   = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    PhLead   = 5'd0,
    PhKw1    = 5'd1,
    PhKw2    = 5'd2,
    PhKw3    = 5'd3,
    PhBlank2 = 5'd4,
    PhYear2  = 5'd5,
    PhYear3  = 5'd6,
    PhYear4  = 5'd7,
    PhDash1  = 5'd8,
    PhMon1   = 5'd9,
    PhMon2   = 5'd10,
    PhDash2  = 5'd11,
    PhDay1   = 5'd12,
    PhDay2   = 5'd13,
    PhSep    = 5'd14,
    PhHour1  = 5'd15,
    PhHour2  = 5'd16,
    PhCol1   = 5'd17,
    PhMin1   = 5'd18,
    PhMin2   = 5'd19,
    PhCol2   = 5'd20,
    PhSec1   = 5'd21,
    PhSec2   = 5'd22,
    PhDone   = 5'd23,
    PhFail   = 5'd24
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct packed {
    logic        send_ack;
    logic        synced;
    stamp_t      stamp;
  } parse_rsp_t;

  typedef struct packed {
    logic        send_request;
    logic        send_ack;
    logic        is_synced;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } out_t;

endpackage

@@ design/time_line_sync_receiver.sv @@
// Time line sync receiver: input register, parser and retry timer, result register.
// Requests pass the input register, then the result register; one per cycle while not
// stalled, and an empty input register fills while the result waits on out_stall_i.
// Reset: parser, sync flag and counters cleared; retry interval 5000, max requests 6.
// Depends on tlsr_pkg, tlsr_parser and tlsr_retry.
`timescale 1ns / 1ps

module time_line_sync_receiver (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tlsr_pkg::in_t    in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tlsr_pkg::out_t   out_rsp_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tlsr_pkg::*;

  logic        in_valid_q;
  in_t         in_q;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic        advance, proc;
  logic [15:0] retry_q;
  logic [7:0]  maxreq_q;
  logic        synced;
  logic        req;
  parse_rsp_t  prsp;
  logic        cfg_wr;

  assign advance    = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_valid_q || advance) in_q <= in_req_i;
  end

  tlsr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_en_i (proc),
    .evt_i    (in_q),
    .synced_o (synced),
    .rsp_o    (prsp)
  );

  tlsr_retry u_retry (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_en_i         (proc),
    .mode_i           (in_q.mode),
    .synced_i         (synced),
    .retry_interval_i (retry_q),
    .max_requests_i   (maxreq_q),
    .send_request_o   (req)
  );

  always_comb begin
    out_d              = '0;
    out_d.send_request = req;
    out_d.send_ack     = prsp.send_ack;
    out_d.is_synced    = prsp.synced;
    out_d.year         = prsp.stamp.year;
    out_d.month        = prsp.stamp.month;
    out_d.day_of_month = prsp.stamp.day_of_month;
    out_d.hour         = prsp.stamp.hour;
    out_d.minute       = prsp.stamp.minute;
    out_d.second       = prsp.stamp.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q  <= RetryIntervalReset;
      maxreq_q <= MaxRequestsReset;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        RegRetryInterval: retry_q  <= pwdata[15:0];
        RegMaxRequests:   maxreq_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      RegRetryInterval: prdata = {16'd0, retry_q};
      RegMaxRequests:   prdata = {24'd0, maxreq_q};
      default:          prdata = '0;
    endcase
  end

  a_ack_synced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.send_ack) |-> out_q.is_synced)
    else $error("ack without sync");

  a_ack_req_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.send_ack && out_q.send_request))
    else $error("ack and request together");

  a_req_unsynced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.send_request) |-> !out_q.is_synced)
    else $error("request while synced");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled with result stage free");

endmodule

@@ design/tlsr_parser.sv @@
// Incremental line parser and sync flag for the time line sync receiver.
// Consumes one event per cycle when evt_en_i is high. Depends on tlsr_pkg.
`timescale 1ns / 1ps

module tlsr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_en_i,
  input  tlsr_pkg::in_t       evt_i,
  output logic                synced_o,
  output tlsr_pkg::parse_rsp_t rsp_o
);
  import tlsr_pkg::*;

  logic                synced_q, synced_d;
  logic [LineCntW-1:0] count_q, count_d;
  phase_e              phase_q, phase_d, phase_char;
  logic [3:0]          pend_q, pend_d;
  stamp_t              acc_q, acc_d, acc_char;

  logic [7:0] ch;
  logic       is_dig, is_blank;
  logic [3:0] dig;
  logic [6:0] pair;

  assign ch       = evt_i.byte_value;
  assign is_dig   = (ch >= ChZero) && (ch <= ChNine);
  assign is_blank = (ch == ChSpace) || (ch == ChTab);
  assign dig      = is_dig ? 4'(ch - ChZero) : 4'd0;
  assign pair     = {pend_q, 3'b000} + {2'b00, pend_q, 1'b0} + {3'b000, dig};

  // one character step of the pattern
  always_comb begin
    phase_char = phase_q;
    pend_d     = pend_q;
    acc_char   = acc_q;
    case (phase_q)
      PhLead: begin
        if (ch == ChT) phase_char = PhKw1;
        else if (!is_blank) phase_char = PhFail;
      end
      PhKw1: phase_char = (ch == ChI) ? PhKw2 : PhFail;
      PhKw2: phase_char = (ch == ChM) ? PhKw3 : PhFail;
      PhKw3: phase_char = (ch == ChE) ? PhBlank2 : PhFail;
      PhBlank2: begin
        if (is_dig) begin
          acc_char.year = {10'd0, dig};
          phase_char    = PhYear2;
        end else if (!is_blank) begin
          phase_char = PhFail;
        end
      end
      PhYear2, PhYear3, PhYear4: begin
        if (is_dig) begin
          acc_char.year = {acc_q.year[10:0], 3'b000} + {acc_q.year[12:0], 1'b0}
                          + {10'd0, dig};
          phase_char    = phase_e'(phase_q + 5'd1);
        end else begin
          phase_char = PhFail;
        end
      end
      PhDash1, PhDash2: phase_char = (ch == ChDash) ? phase_e'(phase_q + 5'd1) : PhFail;
      PhCol1, PhCol2:   phase_char = (ch == ChColon) ? phase_e'(phase_q + 5'd1) : PhFail;
      PhSep: phase_char = ((ch == ChSpace) || (ch == ChT)) ? PhHour1 : PhFail;
      PhMon1, PhDay1, PhHour1, PhMin1, PhSec1: begin
        if (is_dig) begin
          pend_d     = dig;
          phase_char = phase_e'(phase_q + 5'd1);
        end else begin
          phase_char = PhFail;
        end
      end
      PhMon2: begin
        if (is_dig && pair >= 7'd1 && pair <= MonthMax) begin
          acc_char.month = pair[3:0];
          phase_char     = PhDash2;
        end else phase_char = PhFail;
      end
      PhDay2: begin
        if (is_dig && pair >= 7'd1 && pair <= DayMax) begin
          acc_char.day_of_month = pair[4:0];
          phase_char            = PhSep;
        end else phase_char = PhFail;
      end
      PhHour2: begin
        if (is_dig && pair <= HourMax) begin
          acc_char.hour = pair[4:0];
          phase_char    = PhCol1;
        end else phase_char = PhFail;
      end
      PhMin2: begin
        if (is_dig && pair <= MinSecMax) begin
          acc_char.minute = pair[5:0];
          phase_char      = PhCol2;
        end else phase_char = PhFail;
      end
      PhSec2: begin
        if (is_dig && pair <= MinSecMax) begin
          acc_char.second = pair[5:0];
          phase_char      = PhDone;
        end else phase_char = PhFail;
      end
      PhDone:  phase_char = PhDone;
      default: phase_char = PhFail;
    endcase
  end

  // line framing, sync flag and result
  always_comb begin
    synced_d = synced_q;
    count_d  = count_q;
    phase_d  = phase_q;
    acc_d    = acc_q;
    rsp_o    = '0;
    if (evt_en_i) begin
      case (mode_e'(evt_i.mode))
        ModeByte: begin
          if (!synced_q && ch != ChCr) begin
            if (ch == ChLf) begin
              if (phase_q == PhDone) begin
                synced_d       = 1'b1;
                rsp_o.send_ack = 1'b1;
                rsp_o.stamp    = acc_q;
              end
              count_d = '0;
              phase_d = PhLead;
              acc_d   = '0;
            end else if (count_q < LineCntW'(LineCapacity - 1)) begin
              count_d = count_q + 1'b1;
              phase_d = phase_char;
              acc_d   = acc_char;
            end else begin
              count_d = '0;
              phase_d = PhLead;
              acc_d   = '0;
            end
          end
        end
        ModeStart: begin
          synced_d = 1'b0;
          count_d  = '0;
          phase_d  = PhLead;
          acc_d    = '0;
        end
        default: ;
      endcase
    end
    rsp_o.synced = synced_d;
  end

  // pending digit only matters inside a pair; it is reloaded before each use
  logic pend_en;
  assign pend_en = evt_en_i && (mode_e'(evt_i.mode) == ModeByte) && !synced_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q <= 1'b0;
      count_q  <= '0;
      phase_q  <= PhLead;
      acc_q    <= '0;
      pend_q   <= '0;
    end else begin
      synced_q <= synced_d;
      count_q  <= count_d;
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      if (pend_en) pend_q <= pend_d;
    end
  end

  assign synced_o = synced_q;

endmodule

@@ design/tlsr_retry.sv @@
// Request retry timer for the time line sync receiver.
// Counts ticks; sends and counts requests until synced or at the limit, and on start. Depends on tlsr_pkg.
`timescale 1ns / 1ps

module tlsr_retry (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          evt_en_i,
  input  logic [1:0]    mode_i,
  input  logic          synced_i,
  input  logic [15:0]   retry_interval_i,
  input  logic [7:0]    max_requests_i,
  output logic          send_request_o
);
  import tlsr_pkg::*;

  logic [15:0] ms_q, ms_d, ms_inc;
  logic [7:0]  cnt_q, cnt_d;

  assign ms_inc = (ms_q != 16'hFFFF) ? ms_q + 16'd1 : ms_q;

  always_comb begin
    ms_d           = ms_q;
    cnt_d          = cnt_q;
    send_request_o = 1'b0;
    if (evt_en_i) begin
      case (mode_e'(mode_i))
        ModeTick: begin
          ms_d = ms_inc;
          if (!synced_i && cnt_q < max_requests_i && ms_inc >= retry_interval_i) begin
            send_request_o = 1'b1;
            ms_d           = '0;
            if (cnt_q != 8'hFF) cnt_d = cnt_q + 8'd1;
          end
        end
        ModeStart: begin
          send_request_o = 1'b1;
          ms_d           = '0;
          cnt_d          = 8'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q  <= '0;
      cnt_q <= '0;
    end else begin
      ms_q  <= ms_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ bench/tlsr_checker.sv @@
// Checker for the time line sync receiver: watches both request channels and the APB port,
// predicts every result from its own copy of parser, sync and retry state, and compares.
// Depends on tlsr_pkg.
`timescale 1ns / 1ps

module tlsr_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  tlsr_pkg::in_t  in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  tlsr_pkg::out_t out_rsp_i,
  input  logic           psel_i,
  input  logic           penable_i,
  input  logic           pwrite_i,
  input  logic [2:0]     paddr_i,
  input  logic [31:0]    pwdata_i,
  input  logic           pready_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import tlsr_pkg::*;

  logic [15:0] retry_ms;
  logic [7:0]  req_limit;

  logic        synced;
  int unsigned line_len;
  phase_e      phase;
  logic [3:0]  first_digit;
  logic [13:0] year_sum;
  stamp_t      stamp;
  logic [15:0] ms_count;
  logic [7:0]  req_count;

  out_t        status_q[$];

  function automatic void restart_line();
    line_len    = 0;
    phase       = PhLead;
    first_digit = '0;
    year_sum    = '0;
    stamp       = '0;
  endfunction

  function automatic void advance_parser(input logic [7:0] c);
    logic       digit;
    logic       blank;
    logic [3:0] d;
    logic [6:0] pair;
    digit = (c >= ChZero) && (c <= ChNine);
    blank = (c == ChSpace) || (c == ChTab);
    d     = digit ? 4'(c - ChZero) : 4'd0;
    pair  = first_digit * 7'd10 + d;
    case (phase)
      PhLead: begin
        if (c == ChT) phase = PhKw1;
        else if (!blank) phase = PhFail;
      end
      PhKw1: phase = (c == ChI) ? PhKw2 : PhFail;
      PhKw2: phase = (c == ChM) ? PhKw3 : PhFail;
      PhKw3: phase = (c == ChE) ? PhBlank2 : PhFail;
      PhBlank2: begin
        if (digit) begin
          year_sum = 14'(d);
          phase    = PhYear2;
        end else if (!blank) begin
          phase = PhFail;
        end
      end
      PhYear2, PhYear3, PhYear4: begin
        if (digit) begin
          year_sum = year_sum * 14'd10 + d;
          phase    = phase_e'(phase + 5'd1);
        end else begin
          phase = PhFail;
        end
      end
      PhDash1, PhDash2: phase = (c == ChDash) ? phase_e'(phase + 5'd1) : PhFail;
      PhCol1, PhCol2:   phase = (c == ChColon) ? phase_e'(phase + 5'd1) : PhFail;
      PhSep:            phase = (c == ChSpace || c == ChT) ? PhHour1 : PhFail;
      PhMon1, PhDay1, PhHour1, PhMin1, PhSec1: begin
        if (digit) begin
          first_digit = d;
          phase       = phase_e'(phase + 5'd1);
        end else begin
          phase = PhFail;
        end
      end
      PhMon2: begin
        if (digit && pair >= 7'd1 && pair <= MonthMax) begin
          stamp.month = 4'(pair);
          phase       = PhDash2;
        end else begin
          phase = PhFail;
        end
      end
      PhDay2: begin
        if (digit && pair >= 7'd1 && pair <= DayMax) begin
          stamp.day_of_month = 5'(pair);
          phase              = PhSep;
        end else begin
          phase = PhFail;
        end
      end
      PhHour2: begin
        if (digit && pair <= HourMax) begin
          stamp.hour = 5'(pair);
          phase      = PhCol1;
        end else begin
          phase = PhFail;
        end
      end
      PhMin2: begin
        if (digit && pair <= MinSecMax) begin
          stamp.minute = 6'(pair);
          phase        = PhCol2;
        end else begin
          phase = PhFail;
        end
      end
      PhSec2: begin
        if (digit && pair <= MinSecMax) begin
          stamp.second = 6'(pair);
          phase        = PhDone;
        end else begin
          phase = PhFail;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic out_t predict_status(input in_t rq);
    out_t r;
    r = '0;
    case (rq.mode)
      ModeByte: begin
        if (!synced && rq.byte_value != ChCr) begin
          if (rq.byte_value == ChLf) begin
            if (phase == PhDone) begin
              synced         = 1'b1;
              r.send_ack     = 1'b1;
              r.year         = year_sum;
              r.month        = stamp.month;
              r.day_of_month = stamp.day_of_month;
              r.hour         = stamp.hour;
              r.minute       = stamp.minute;
              r.second       = stamp.second;
            end
            restart_line();
          end else if (line_len < LineCapacity - 1) begin
            line_len++;
            advance_parser(rq.byte_value);
          end else begin
            restart_line();
          end
        end
      end
      ModeTick: begin
        if (ms_count != 16'hFFFF) ms_count++;
        if (!synced && req_count < req_limit && ms_count >= retry_ms) begin
          r.send_request = 1'b1;
          ms_count       = '0;
          if (req_count != 8'hFF) req_count++;
        end
      end
      ModeStart: begin
        synced = 1'b0;
        restart_line();
        ms_count       = '0;
        req_count      = 8'd1;
        r.send_request = 1'b1;
      end
      default: ;
    endcase
    r.is_synced = synced;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_t want;
    if (!rst_ni) begin
      retry_ms  = RetryIntervalReset;
      req_limit = MaxRequestsReset;
      synced    = 1'b0;
      restart_line();
      ms_count  = '0;
      req_count = '0;
      status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (status_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_rsp_i);
        end else begin
          want = status_q.pop_front();
          check_field("send_request", want.send_request, out_rsp_i.send_request);
          check_field("send_ack", want.send_ack, out_rsp_i.send_ack);
          check_field("is_synced", want.is_synced, out_rsp_i.is_synced);
          check_field("year", want.year, out_rsp_i.year);
          check_field("month", want.month, out_rsp_i.month);
          check_field("day_of_month", want.day_of_month, out_rsp_i.day_of_month);
          check_field("hour", want.hour, out_rsp_i.hour);
          check_field("minute", want.minute, out_rsp_i.minute);
          check_field("second", want.second, out_rsp_i.second);
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0)
        status_q.push_back(predict_status(in_req_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (reg_e'(paddr_i[2]) == RegRetryInterval) retry_ms = pwdata_i[15:0];
        else req_limit = pwdata_i[7:0];
      end
      pending_o = status_q.size();
    end
  end

endmodule

@@ bench/time_line_sync_receiver_tb.sv @@
// Testbench top for the time line sync receiver: clock, reset, APB setup and
// random time lines, ticks and start requests with idle gaps on both sides.
// Depends on tlsr_pkg, time_line_sync_receiver and tlsr_checker.
`timescale 1ns / 1ps

module time_line_sync_receiver_tb;
  import tlsr_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned DrainCycles   = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_req;
  logic        out_valid;
  logic        out_stall;
  out_t        out_rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [7:0]  txt[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  time_line_sync_receiver u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tlsr_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return lo;
    if (r == 1) return hi;
    if (r == 2) return $urandom_range(0, 99);
    return $urandom_range(lo, hi);
  endfunction

  function automatic void put_pair(input int unsigned v);
    txt.push_back(8'(ChZero + v / 10));
    txt.push_back(8'(ChZero + v % 10));
  endfunction

  function automatic void queue_text(input string s);
    foreach (s[i]) txt.push_back(s[i]);
  endfunction

  task automatic send_event(input mode_e m, input logic [7:0] b);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{mode: m, byte_value: b};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (m != ModeNone) sent++;
  endtask

  task automatic send_txt(input int unsigned tick_pct);
    while (txt.size() != 0) begin
      if ($urandom_range(0, 99) < tick_pct) send_event(ModeTick, 8'($urandom));
      else send_event(ModeByte, txt.pop_front());
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] retry, input logic [7:0] limit);
    write_reg(RegRetryInterval, {16'($urandom), retry});
    write_reg(RegMaxRequests, {24'($urandom), limit});
  endtask

  initial begin : sink
    bit          hold;
    int unsigned len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = 1'b1;
        len      = HoldOffCycles;
      end else if (calm) begin
        hold = 1'b0;
        len  = 1;
      end else begin
        hold = ($urandom_range(0, 3) == 0);
        len  = hold ? 1 + gap_len() : $urandom_range(1, 16);
      end
      out_stall <= hold;
      repeat (len) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned goal;
    int unsigned pick;
    int unsigned y;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_req   <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no start yet, then one full valid line with CR
    send_event(ModeNone, 8'hFF);
    send_event(ModeTick, 8'h00);
    send_event(ModeByte, 8'h00);
    send_event(ModeByte, ChLf);
    send_event(ModeStart, 8'hA5);
    queue_text("TIME9999-12-31T23:59:59");
    txt.push_back(ChCr);
    txt.push_back(ChLf);
    send_txt(0);
    send_event(ModeByte, ChT);
    send_event(ModeTick, 8'h5A);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(16'd1, 8'd255);
        1: set_config(16'd0, 8'd0);
        2: set_config(16'hFFFF, 8'd1);
        3: set_config(16'd2, 8'd3);
        4: set_config(16'($urandom_range(0, 12)), 8'($urandom_range(0, 8)));
        default: begin
          set_config(16'd5, 8'd255);
          hold_req = 1'b1;
        end
      endcase
      goal = sent + ItemsPerPhase;
      while (sent < goal) begin
        calm = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          repeat ($urandom_range(1, 8)) send_event(mode_e'($urandom_range(0, 3)), 8'($urandom));
        end else if (pick < 18) begin
          repeat ($urandom_range(1, 12)) send_event(ModeTick, 8'($urandom));
        end else begin
          if ($urandom_range(0, 3) != 0) send_event(ModeStart, 8'($urandom));
          // overlong prefix: the line may lose one or more of its first characters
          if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(60, 66)) txt.push_back(8'($urandom_range(33, 126)));
          repeat ($urandom_range(0, 2)) txt.push_back($urandom_range(0, 1) ? ChTab : ChSpace);
          queue_text("TIME");
          repeat ($urandom_range(0, 2)) txt.push_back($urandom_range(0, 1) ? ChTab : ChSpace);
          y = pick_field(0, 9999);
          put_pair(y / 100);
          put_pair(y % 100);
          txt.push_back(ChDash);
          put_pair(pick_field(1, 12));
          txt.push_back(ChDash);
          put_pair(pick_field(1, 31));
          txt.push_back($urandom_range(0, 1) ? ChT : ChSpace);
          put_pair(pick_field(0, 23));
          txt.push_back(ChColon);
          put_pair(pick_field(0, 59));
          txt.push_back(ChColon);
          put_pair(pick_field(0, 59));
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom));
          if ($urandom_range(0, 7) == 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
          if ($urandom_range(0, 1) == 0) txt.push_back(ChCr);
          txt.push_back(ChLf);
          send_txt(8);
        end
      end
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
